// File: hw/rtl/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared constants and types of the LZSS window decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

   // history window geometry
   localparam int WINDOW_SIZE = 4096;
   localparam int ADDR_W      = $clog2(WINDOW_SIZE);
   localparam int MAX_MATCH   = 18;
   localparam int LEN_W       = $clog2(MAX_MATCH + 1);

   // first write position after a stream start
   localparam logic [ADDR_W-1:0] START_POS = ADDR_W'(WINDOW_SIZE - MAX_MATCH);

   // shortest reference copy
   localparam logic [LEN_W-1:0] MIN_MATCH = LEN_W'(3);

   // token parser phase
   typedef enum logic [1:0] {
      PH_FLAG,
      PH_TOKEN,
      PH_REF
   } phase_type;

   // sequencer state
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LIT,
      ST_COPY
   } state_type;

endpackage

// File: hw/rtl/lzwd_ram.sv
// ----------------------------------------------------------------------------
// lzwd_ram
// Simple dual-port RAM, one write and one read port, registered read data
// that holds while the read enable is low.
// ----------------------------------------------------------------------------
module lzwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/lzss_window_decoder.sv
// ----------------------------------------------------------------------------
// lzss_window_decoder
// LZSS stream decoder with a 4096-byte history window and copies of up to
// 18 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one compressed byte per request. req_tuser marks the first
//   header byte of a stream (restarts the decoder, empties the window) and
//   req_tlast the final byte (later bytes are dropped until the next start).
//   rsp_* gives decoded bytes; rsp_tuser[0] flags a data byte, rsp_tuser[1]
//   an overrun (declared length exceeded, decoding stops), rsp_tlast the last
//   response caused by one request.
// Timing:
//   Header, flag and first reference bytes give nothing. A literal gives one
//   byte. A reference of n bytes runs as accept, first window read, then one
//   byte a cycle while rsp_tready does not hold the copy; the single window
//   read port fetches one byte per cycle.
//   A read of a byte written in the same cycle is forwarded.
// Reset:
//   The decoder is halted until a byte with req_tuser set. The window needs
//   no clearing pass: entries not yet written in the current stream are
//   told apart by the output byte count and read as zero.
// Back-pressure:
//   One output register; while rsp_tready is low the copy holds in place.
//   A new request is taken as soon as the previous one is fully issued.
// ----------------------------------------------------------------------------
module lzss_window_decoder (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] first
   input  logic       req_tlast,   // in_last
   // response channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] byte_valid, [1] overrun
   output logic       rsp_tlast    // run_last
);

   import lzwd_pkg::*;

   // sequencer and stream state
   state_type         state_ff, state_in;
   logic              halted_ff, halted_in;
   logic [ADDR_W-1:0] write_pos_ff, write_pos_in;
   logic [15:0]       flag_ff, flag_in;
   phase_type         phase_ff, phase_in;
   logic [7:0]        offset_ff, offset_in;
   logic [2:0]        hdr_cnt_ff, hdr_cnt_in;
   logic [31:0]       decl_len_ff, decl_len_in;
   logic [31:0]       written_ff, written_in;

   // literal and copy registers
   logic [7:0]        lit_ff, lit_in;
   logic [ADDR_W-1:0] copy_pos_ff, copy_pos_in;
   logic [LEN_W-1:0]  copy_left_ff, copy_left_in;
   logic              pend_ff, pend_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              fwd_ff, fwd_in;
   logic [7:0]        fwd_data_ff, fwd_data_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic [1:0]        rsp_user_ff, rsp_user_in;
   logic              rsp_last_ff, rsp_last_in;

   // combinational
   logic              accept;
   logic              out_free;
   logic              emit_go;
   logic              fits;
   logic [7:0]        emit_data;
   logic              wr_en;
   logic              rd_en;
   logic [7:0]        rd_data;
   logic [ADDR_W-1:0] rel_addr;
   logic              addr_written;
   logic              last_of_copy;
   logic              done_copy;
   logic              go_lit;
   logic              go_copy;

   // history window
   lzwd_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW_SIZE)
   ) u_hist (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (write_pos_ff),
      .wr_data (emit_data),
      .rd_en   (rd_en),
      .rd_addr (copy_pos_ff),
      .rd_data (rd_data)
   );

   // handshake and emit control
   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign emit_go      = out_free && ((state_ff == ST_LIT) ||
                                      ((state_ff == ST_COPY) && pend_ff));
   assign fits         = written_ff < decl_len_ff;
   assign wr_en        = emit_go && fits;
   assign last_of_copy = (copy_left_ff == LEN_W'(1));
   assign done_copy    = emit_go && (state_ff == ST_COPY) && (!fits || last_of_copy);
   assign rd_en        = (state_ff == ST_COPY) &&
                         (!pend_ff || (wr_en && !last_of_copy));

   // byte to emit: literal, forwarded write, window data or zero if unwritten
   always_comb begin
      if (state_ff == ST_LIT) begin
         emit_data = lit_ff;
      end else if (fwd_ff) begin
         emit_data = fwd_data_ff;
      end else if (rd_valid_ff) begin
         emit_data = rd_data;
      end else begin
         emit_data = 8'd0;
      end
   end

   // an entry holds data of this stream if it lies in the written range
   assign rel_addr     = copy_pos_ff - START_POS;
   assign addr_written = (|written_ff[31:ADDR_W]) || (rel_addr < written_ff[ADDR_W-1:0]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go_lit) begin
               state_in = ST_LIT;
            end else if (go_copy) begin
               state_in = ST_COPY;
            end
         end
         ST_LIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_COPY: begin
            if (done_copy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      halted_in    = halted_ff;
      write_pos_in = write_pos_ff;
      flag_in      = flag_ff;
      phase_in     = phase_ff;
      offset_in    = offset_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      decl_len_in  = decl_len_ff;
      written_in   = written_ff;
      lit_in       = lit_ff;
      copy_pos_in  = copy_pos_ff;
      copy_left_in = copy_left_ff;
      pend_in      = pend_ff;
      rd_valid_in  = rd_valid_ff;
      fwd_in       = fwd_ff;
      fwd_data_in  = fwd_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      go_lit       = 1'b0;
      go_copy      = 1'b0;

      // request decode
      if (accept) begin
         if (req_tuser) begin
            halted_in    = 1'b0;
            write_pos_in = START_POS;
            flag_in      = 16'd0;
            phase_in     = PH_FLAG;
            offset_in    = 8'd0;
            hdr_cnt_in   = 3'd0;
            decl_len_in  = 32'd0;
            written_in   = 32'd0;
         end
         if (!halted_in) begin
            if (!hdr_cnt_in[2]) begin
               decl_len_in = decl_len_in | ({24'd0, req_tdata} << {hdr_cnt_in[1:0], 3'b000});
               hdr_cnt_in  = hdr_cnt_in + 3'd1;
            end else begin
               case (phase_in)
                  PH_FLAG: begin
                     flag_in  = {8'hff, req_tdata};
                     phase_in = PH_TOKEN;
                  end
                  PH_TOKEN: begin
                     if (flag_in[0]) begin
                        lit_in = req_tdata;
                        go_lit = 1'b1;
                     end else begin
                        offset_in = req_tdata;
                        phase_in  = PH_REF;
                     end
                  end
                  PH_REF: begin
                     copy_pos_in  = {req_tdata[7:4], offset_in};
                     copy_left_in = LEN_W'(req_tdata[3:0]) + MIN_MATCH;
                     pend_in      = 1'b0;
                     go_copy      = 1'b1;
                  end
                  default: phase_in = PH_FLAG;
               endcase
            end
         end
         if (req_tlast) begin
            halted_in = 1'b1;
         end
      end

      // one result per emit cycle
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         if (!fits) begin
            halted_in   = 1'b1;
            rsp_data_in = 8'd0;
            rsp_user_in = 2'b10;
            rsp_last_in = 1'b1;
         end else begin
            written_in   = written_ff + 32'd1;
            write_pos_in = write_pos_ff + ADDR_W'(1);
            rsp_data_in  = emit_data;
            rsp_user_in  = 2'b01;
            rsp_last_in  = (state_ff == ST_LIT) || last_of_copy;
            if ((state_ff == ST_LIT) || last_of_copy) begin
               flag_in  = {1'b0, flag_ff[15:1]};
               phase_in = flag_ff[9] ? PH_TOKEN : PH_FLAG;
            end
         end
         if (state_ff == ST_COPY) begin
            copy_left_in = copy_left_ff - LEN_W'(1);
         end
      end

      // window read issue, with forwarding of the byte written alongside
      if (rd_en) begin
         copy_pos_in = copy_pos_ff + ADDR_W'(1);
         pend_in     = 1'b1;
         rd_valid_in = addr_written;
         fwd_in      = wr_en && (copy_pos_ff == write_pos_ff);
         fwd_data_in = emit_data;
      end else if (done_copy) begin
         pend_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         halted_ff    <= 1'b1;
         write_pos_ff <= START_POS;
         flag_ff      <= 16'd0;
         phase_ff     <= PH_FLAG;
         offset_ff    <= 8'd0;
         hdr_cnt_ff   <= 3'd0;
         decl_len_ff  <= 32'd0;
         written_ff   <= 32'd0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         halted_ff    <= halted_in;
         write_pos_ff <= write_pos_in;
         flag_ff      <= flag_in;
         phase_ff     <= phase_in;
         offset_ff    <= offset_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         decl_len_ff  <= decl_len_in;
         written_ff   <= written_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lit_ff       <= lit_in;
      copy_pos_ff  <= copy_pos_in;
      copy_left_ff <= copy_left_in;
      rd_valid_ff  <= rd_valid_in;
      fwd_ff       <= fwd_in;
      fwd_data_ff  <= fwd_data_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_ovr_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff[1]) |-> (rsp_last_ff && !rsp_user_ff[0]))
      else $error("overrun response must end the run and carry no byte");

   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_ff)
      else $error("window read still in flight while idle");

   a_copy_count: assert property (@(posedge clock) disable iff (reset)
      (emit_go && (state_ff == ST_COPY)) |-> (copy_left_ff != LEN_W'(0)))
      else $error("copy emitted with no bytes left");

   a_ovr_halts: assert property (@(posedge clock) disable iff (reset)
      (emit_go && !fits) |=> (halted_ff && (state_ff == ST_IDLE)))
      else $error("decoder did not halt after overrun");

endmodule
